FILE: src/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge
`define MMLP_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define MMLP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mmlp_pkg.sv
package mmlp_pkg;

    localparam int LINE_LENGTH_DEF = 4096;
    localparam int NUM_W           = 64;
    localparam int NAME_POS_W      = 12;
    localparam int CHAR_W          = 8;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h73;

    typedef enum logic [3:0] {
        PH_START       = 4'd0,
        PH_END         = 4'd1,
        PH_PERM_R      = 4'd2,
        PH_PERM_W      = 4'd3,
        PH_PERM_X      = 4'd4,
        PH_PERM_P      = 4'd5,
        PH_SEP_PERM    = 4'd6,
        PH_OFFSET      = 4'd7,
        PH_DEV_FIRST   = 4'd8,
        PH_DEV_REST    = 4'd9,
        PH_INODE_FIRST = 4'd10,
        PH_INODE_REST  = 4'd11,
        PH_PATH_SKIP   = 4'd12,
        PH_PATH        = 4'd13,
        PH_DONE        = 4'd14
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              line_end;
    } item_t;

    typedef struct packed {
        logic                  parse_error;
        logic [NAME_POS_W-1:0] name_position;
        logic                  has_name;
        logic                  is_private;
        logic                  can_exec;
        logic                  can_write;
        logic                  can_read;
        logic [NUM_W-1:0]      file_offset;
        logic [NUM_W-1:0]      range_end;
        logic [NUM_W-1:0]      range_start;
    } result_t;

endpackage

FILE: src/mmlp_in_reg.sv
module mmlp_in_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mmlp_pkg::item_t in_item,
    output logic            held_valid,
    output mmlp_pkg::item_t held_item,
    input  logic            take
);

    logic            valid_reg;
    logic            valid_next;
    mmlp_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: src/mmlp_core.sv
module mmlp_core #(
    parameter int LINE_LENGTH = mmlp_pkg::LINE_LENGTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mmlp_pkg::item_t   item,
    output logic              res_valid,
    output mmlp_pkg::result_t res
);

    localparam int IDX_W = $clog2(LINE_LENGTH + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(LINE_LENGTH);

    mmlp_pkg::phase_t phase_reg, phase_next;
    logic [mmlp_pkg::NUM_W-1:0]      start_reg, start_next;
    logic [mmlp_pkg::NUM_W-1:0]      end_reg, end_next;
    logic [mmlp_pkg::NUM_W-1:0]      offs_reg, offs_next;
    logic [3:0]                      perm_reg, perm_next;
    logic                            digit_reg, digit_next;
    logic [IDX_W-1:0]                cidx_reg, cidx_next;
    logic [mmlp_pkg::NAME_POS_W-1:0] pidx_reg, pidx_next;
    logic                            found_reg, found_next;
    logic                            err_reg, err_next;

    logic [mmlp_pkg::CHAR_W-1:0] c;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       line_full;
    logic       char_take;
    logic       line_close;
    logic       final_err;

    assign c          = item.char_code;
    assign line_full  = (cidx_reg == IDX_MAX);
    assign char_take  = fire && !item.line_end && !err_reg && !line_full;
    assign line_close = fire && item.line_end;

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hex_val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            hex_val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            hex_val = 4'(c - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (line_close)
        begin
            phase_next = mmlp_pkg::PH_START;
        end
        else if (char_take)
        begin
            unique case (phase_reg)
                mmlp_pkg::PH_START:
                    if (!is_hex && c == mmlp_pkg::CH_DASH && digit_reg)
                        phase_next = mmlp_pkg::PH_END;
                mmlp_pkg::PH_END:
                    if (!is_hex && c == mmlp_pkg::CH_SPACE && digit_reg)
                        phase_next = mmlp_pkg::PH_PERM_R;
                mmlp_pkg::PH_PERM_R:
                    if (c == mmlp_pkg::CH_R || c == mmlp_pkg::CH_DASH)
                        phase_next = mmlp_pkg::PH_PERM_W;
                mmlp_pkg::PH_PERM_W:
                    if (c == mmlp_pkg::CH_W || c == mmlp_pkg::CH_DASH)
                        phase_next = mmlp_pkg::PH_PERM_X;
                mmlp_pkg::PH_PERM_X:
                    if (c == mmlp_pkg::CH_X || c == mmlp_pkg::CH_DASH)
                        phase_next = mmlp_pkg::PH_PERM_P;
                mmlp_pkg::PH_PERM_P:
                    if (c == mmlp_pkg::CH_P || c == mmlp_pkg::CH_S)
                        phase_next = mmlp_pkg::PH_SEP_PERM;
                mmlp_pkg::PH_SEP_PERM:
                    if (c == mmlp_pkg::CH_SPACE)
                        phase_next = mmlp_pkg::PH_OFFSET;
                mmlp_pkg::PH_OFFSET:
                    if (!is_hex && c == mmlp_pkg::CH_SPACE && digit_reg)
                        phase_next = mmlp_pkg::PH_DEV_FIRST;
                mmlp_pkg::PH_DEV_FIRST:
                    if (c != mmlp_pkg::CH_NUL)
                        phase_next = mmlp_pkg::PH_DEV_REST;
                mmlp_pkg::PH_DEV_REST:
                    if (c == mmlp_pkg::CH_SPACE)
                        phase_next = mmlp_pkg::PH_INODE_FIRST;
                mmlp_pkg::PH_INODE_FIRST:
                    if (c != mmlp_pkg::CH_NUL)
                        phase_next = mmlp_pkg::PH_INODE_REST;
                mmlp_pkg::PH_INODE_REST:
                    if (c == mmlp_pkg::CH_SPACE)
                        phase_next = mmlp_pkg::PH_PATH_SKIP;
                mmlp_pkg::PH_PATH_SKIP:
                    if (c == mmlp_pkg::CH_NUL)
                        phase_next = mmlp_pkg::PH_DONE;
                    else if (c != mmlp_pkg::CH_SPACE)
                        phase_next = mmlp_pkg::PH_PATH;
                mmlp_pkg::PH_PATH:
                    if (c == mmlp_pkg::CH_NUL)
                        phase_next = mmlp_pkg::PH_DONE;
                mmlp_pkg::PH_DONE:
                    phase_next = mmlp_pkg::PH_DONE;
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    // accumulators, flags and counters
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        offs_next  = offs_reg;
        perm_next  = perm_reg;
        digit_next = digit_reg;
        cidx_next  = cidx_reg;
        pidx_next  = pidx_reg;
        found_next = found_reg;
        err_next   = err_reg;

        if (line_close)
        begin
            start_next = '0;
            end_next   = '0;
            offs_next  = '0;
            perm_next  = '0;
            digit_next = 1'b0;
            cidx_next  = '0;
            pidx_next  = '0;
            found_next = 1'b0;
            err_next   = 1'b0;
        end
        else if (fire)
        begin
            if (!line_full)
            begin
                cidx_next = cidx_reg + IDX_W'(1);
            end
            else if (!err_reg)
            begin
                err_next = 1'b1;
            end

            if (char_take)
            begin
                unique case (phase_reg)
                    mmlp_pkg::PH_START:
                        if (is_hex)
                        begin
                            if (start_reg[63:60] != 4'd0) err_next = 1'b1;
                            else
                            begin
                                start_next = {start_reg[59:0], hex_val};
                                digit_next = 1'b1;
                            end
                        end
                        else if (c == mmlp_pkg::CH_DASH && digit_reg) digit_next = 1'b0;
                        else err_next = 1'b1;
                    mmlp_pkg::PH_END:
                        if (is_hex)
                        begin
                            if (end_reg[63:60] != 4'd0) err_next = 1'b1;
                            else
                            begin
                                end_next   = {end_reg[59:0], hex_val};
                                digit_next = 1'b1;
                            end
                        end
                        else if (c == mmlp_pkg::CH_SPACE && digit_reg) digit_next = 1'b0;
                        else err_next = 1'b1;
                    mmlp_pkg::PH_OFFSET:
                        if (is_hex)
                        begin
                            if (offs_reg[63:60] != 4'd0) err_next = 1'b1;
                            else
                            begin
                                offs_next  = {offs_reg[59:0], hex_val};
                                digit_next = 1'b1;
                            end
                        end
                        else if (c == mmlp_pkg::CH_SPACE && digit_reg) digit_next = 1'b0;
                        else err_next = 1'b1;
                    mmlp_pkg::PH_PERM_R:
                        if (c == mmlp_pkg::CH_R) perm_next[0] = 1'b1;
                        else if (c != mmlp_pkg::CH_DASH) err_next = 1'b1;
                    mmlp_pkg::PH_PERM_W:
                        if (c == mmlp_pkg::CH_W) perm_next[1] = 1'b1;
                        else if (c != mmlp_pkg::CH_DASH) err_next = 1'b1;
                    mmlp_pkg::PH_PERM_X:
                        if (c == mmlp_pkg::CH_X) perm_next[2] = 1'b1;
                        else if (c != mmlp_pkg::CH_DASH) err_next = 1'b1;
                    mmlp_pkg::PH_PERM_P:
                        if (c == mmlp_pkg::CH_P) perm_next[3] = 1'b1;
                        else if (c != mmlp_pkg::CH_S) err_next = 1'b1;
                    mmlp_pkg::PH_SEP_PERM:
                        if (c != mmlp_pkg::CH_SPACE) err_next = 1'b1;
                    mmlp_pkg::PH_DEV_FIRST, mmlp_pkg::PH_DEV_REST,
                    mmlp_pkg::PH_INODE_FIRST, mmlp_pkg::PH_INODE_REST:
                        if (c == mmlp_pkg::CH_NUL) err_next = 1'b1;
                    mmlp_pkg::PH_PATH_SKIP:
                        if (c != mmlp_pkg::CH_NUL && c != mmlp_pkg::CH_SPACE)
                        begin
                            found_next = 1'b1;
                            pidx_next  = mmlp_pkg::NAME_POS_W'(cidx_reg);
                        end
                    mmlp_pkg::PH_PATH, mmlp_pkg::PH_DONE:
                        err_next = err_reg;
                    default:
                        err_next = 1'b1;
                endcase
            end
        end
    end

    // result on the terminator
    assign final_err = err_reg || !(phase_reg == mmlp_pkg::PH_PATH_SKIP ||
                                    phase_reg == mmlp_pkg::PH_PATH ||
                                    phase_reg == mmlp_pkg::PH_DONE);
    assign res_valid = line_close;

    always_comb
    begin
        res = '0;
        if (final_err)
        begin
            res.parse_error = 1'b1;
        end
        else
        begin
            res.range_start   = start_reg;
            res.range_end     = end_reg;
            res.file_offset   = offs_reg;
            res.can_read      = perm_reg[0];
            res.can_write     = perm_reg[1];
            res.can_exec      = perm_reg[2];
            res.is_private    = perm_reg[3];
            res.has_name      = found_reg;
            res.name_position = found_reg ? pidx_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mmlp_pkg::PH_START;
            start_reg <= '0;
            end_reg   <= '0;
            offs_reg  <= '0;
            perm_reg  <= '0;
            digit_reg <= 1'b0;
            cidx_reg  <= '0;
            pidx_reg  <= '0;
            found_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            offs_reg  <= offs_next;
            perm_reg  <= perm_next;
            digit_reg <= digit_next;
            cidx_reg  <= cidx_next;
            pidx_reg  <= pidx_next;
            found_reg <= found_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: src/memory_map_line_parser_unit.sv
// Memory map line parser: takes one character of a memory map text line per
// request on the slave side (tlast marks the terminator request, whose tdata
// is ignored) and returns one result request per line on the master side.
// One character is taken every cycle; the only backpressure comes from a
// terminator meeting a full result register. A result is offered on the
// master side after its terminator is accepted: the terminator is held in
// the input register until the result register can take a result, which is
// then loaded into it. When parse_error is set all other result fields are
// zero. Lines longer than LINE_LENGTH characters are flagged as errors. No
// clearing pass is needed after reset.
`include "assert_macros.svh"

module memory_map_line_parser_unit #(
    parameter int LINE_LENGTH = mmlp_pkg::LINE_LENGTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
    input  logic         s_axis_tlast,   // line_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] range_start, [127:64] range_end, [191:128] file_offset,
    // [192] can_read, [193] can_write, [194] can_exec, [195] is_private,
    // [196] has_name, [208:197] name_position, [209] parse_error, rest zero
    output logic [215:0] m_axis_tdata
);

    mmlp_pkg::item_t   s_item;
    mmlp_pkg::item_t   held_item;
    logic              held_valid;
    logic              advance;
    logic              fire;
    logic              res_valid;
    mmlp_pkg::result_t res;

    logic              out_valid_reg, out_valid_next;
    mmlp_pkg::result_t out_data_reg;

    assign s_item.char_code = s_axis_tdata;
    assign s_item.line_end  = s_axis_tlast;

    assign advance = !out_valid_reg || m_axis_tready;
    assign fire    = held_valid && (!held_item.line_end || advance);

    mmlp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (s_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (fire)
    );

    mmlp_core #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_data_reg};

    `MMLP_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_reg |-> s_axis_tready,
        "input stalled with empty result register")
    `MMLP_ASSERT_NEXT(a_result_loaded, res_valid, out_valid_reg,
        "terminator did not produce a result")
    `MMLP_ASSERT_ALWAYS(a_error_clean,
        (out_valid_reg && out_data_reg.parse_error) |->
        (out_data_reg.range_start == '0 && out_data_reg.range_end == '0 &&
         out_data_reg.file_offset == '0 && out_data_reg.has_name == 1'b0),
        "error result carries data")
    `MMLP_ASSERT_ALWAYS(a_pos_needs_name,
        (out_valid_reg && !out_data_reg.has_name) |-> (out_data_reg.name_position == '0),
        "name position without a name")

endmodule
